[design/nvfp4_pkg.sv]
// Shared types and constants of the NVFP4 block-scaled dot product.
// Used by the front end, the item queue and the accumulate back end.
`timescale 1ns / 1ps
package nvfp4_pkg;

    localparam int QDEPTH = 2;
    localparam int QAW    = 1;
    localparam int SIG_W  = 53;
    localparam int EXT_W  = 56;

    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] F32_INF  = 32'h7F80_0000;

    typedef struct packed {
        logic               nan;
        logic               inf;
        logic               zero;
        logic               sign;
        logic [31:0]        prod;
        logic signed [9:0]  expo;
    } t_elem;

    typedef struct packed {
        t_elem first;
        t_elem second;
        logic  second_present;
        logic  row_end;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_ALIGN,
        S_ADD,
        S_LZC,
        S_SHIFT,
        S_ROUND,
        S_EMIT
    } t_state;

    function automatic logic [3:0] e2m1_halves(input logic [2:0] code);
        logic [3:0] h;
        unique case (code)
            3'd0:    h = 4'd0;
            3'd1:    h = 4'd1;
            3'd2:    h = 4'd2;
            3'd3:    h = 4'd3;
            3'd4:    h = 4'd4;
            3'd5:    h = 4'd6;
            3'd6:    h = 4'd8;
            3'd7:    h = 4'd12;
            default: h = 4'd0;
        endcase
        return h;
    endfunction

endpackage

[design/nvfp4_front.sv]
// Front end: decodes E2M1 weights and the E4M3 scale, forms exact products.
// Depends on nvfp4_pkg.
`timescale 1ns / 1ps
module nvfp4_front (
    input  logic [7:0]        i_weight_pair,
    input  logic [7:0]        i_block_scale,
    input  logic [31:0]       i_activation_first,
    input  logic [31:0]       i_activation_second,
    input  logic              i_second_present,
    input  logic              i_row_end,
    output nvfp4_pkg::t_item  o_item
);
    import nvfp4_pkg::*;

    logic              w_s_nan;
    logic [3:0]        w_s_exp;
    logic [3:0]        w_s_mant;
    logic signed [5:0] w_w_exp;

    function automatic t_elem make_elem(input logic [3:0] code, input logic [31:0] act,
                                        input logic [3:0] s_mant,
                                        input logic signed [5:0] w_exp,
                                        input logic s_nan, input logic s_sign);
        logic [7:0]        h_mag;
        logic [23:0]       a_mant;
        logic [7:0]        a_exp;
        logic [7:0]        a_exp_eff;
        logic              a_nan;
        logic              a_inf;
        logic signed [9:0] a_e;
        t_elem             el;
        h_mag     = {4'b0, e2m1_halves(code[2:0])} * {4'b0, s_mant};
        a_exp     = act[30:23];
        a_mant    = (a_exp == 8'd0) ? {1'b0, act[22:0]} : {1'b1, act[22:0]};
        a_exp_eff = (a_exp == 8'd0) ? 8'd1 : a_exp;
        a_nan     = (a_exp == 8'hFF) && (act[22:0] != 23'd0);
        a_inf     = (a_exp == 8'hFF) && (act[22:0] == 23'd0);
        a_e       = $signed({2'b00, a_exp_eff}) - 10'sd150;
        el.prod   = {24'b0, h_mag} * {8'b0, a_mant};
        el.expo   = a_e + $signed({{4{w_exp[5]}}, w_exp});
        el.sign   = code[3] ^ s_sign ^ act[31];
        el.nan    = s_nan | a_nan | (a_inf && (h_mag == 8'd0));
        el.inf    = !s_nan && a_inf && (h_mag != 8'd0);
        el.zero   = !el.nan && !el.inf && (el.prod == 32'd0);
        return el;
    endfunction

    assign w_s_nan  = (i_block_scale[6:0] == 7'h7F);
    assign w_s_exp  = i_block_scale[6:3];
    assign w_s_mant = (w_s_exp == 4'd0) ? {1'b0, i_block_scale[2:0]}
                                        : {1'b1, i_block_scale[2:0]};
    assign w_w_exp  = (w_s_exp == 4'd0) ? -6'sd10 : $signed({2'b00, w_s_exp}) - 6'sd11;

    always_comb begin
        o_item.first  = make_elem(i_weight_pair[3:0], i_activation_first, w_s_mant,
                                  w_w_exp, w_s_nan, i_block_scale[7]);
        o_item.second = make_elem(i_weight_pair[7:4], i_activation_second, w_s_mant,
                                  w_w_exp, w_s_nan, i_block_scale[7]);
        o_item.second_present = i_second_present;
        o_item.row_end        = i_row_end;
    end

endmodule

[design/nvfp4_queue.sv]
// Short queue of decoded words between front end and back end.
// Depends on nvfp4_pkg.
`timescale 1ns / 1ps
module nvfp4_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  nvfp4_pkg::t_item  i_data,
    output logic              o_full,
    input  logic              i_rd,
    output logic              o_empty,
    output nvfp4_pkg::t_item  o_data
);
    import nvfp4_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;
    logic [QAW-1:0] n_wr_ptr;
    logic [QAW-1:0] n_rd_ptr;
    logic [QAW:0]   n_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + {{QAW{1'b0}}, i_wr} - {{QAW{1'b0}}, i_rd};
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full) else $error("queue write while full");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty) else $error("queue read while empty");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH)) else $error("queue count beyond depth");
`endif

endmodule

[design/nvfp4_back.sv]
// Back end: binary64 accumulate of exact products, binary32 rounding, result word.
// Depends on nvfp4_pkg.
`timescale 1ns / 1ps
module nvfp4_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nvfp4_pkg::t_item  i_item,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [31:0]       o_row_result
);
    import nvfp4_pkg::*;

    t_state             r_state, n_state;
    t_item              r_item, n_item;
    logic               r_idx, n_idx;
    logic               r_acc_sign, n_acc_sign;
    logic               r_acc_zero, n_acc_zero;
    logic               r_acc_inf, n_acc_inf;
    logic               r_acc_nan, n_acc_nan;
    logic signed [11:0] r_acc_exp, n_acc_exp;
    logic [SIG_W-1:0]   r_acc_sig, n_acc_sig;
    logic               r_b_sign, n_b_sign;
    logic signed [11:0] r_b_exp, n_b_exp;
    logic [SIG_W-1:0]   r_b_sig, n_b_sig;
    logic [EXT_W-1:0]   r_big, n_big;
    logic [EXT_W-1:0]   r_small, n_small;
    logic signed [11:0] r_exp, n_exp;
    logic               r_sign, n_sign;
    logic               r_sub, n_sub;
    logic [EXT_W:0]     r_sum, n_sum;
    logic [5:0]         r_lz, n_lz;
    logic [EXT_W-1:0]   r_norm, n_norm;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_out_data, n_out_data;

    t_elem              w_cur;
    logic               w_last_elem;
    t_state             w_after;
    logic               w_norm_short;
    logic [4:0]         w_k;
    logic               w_a_ge;
    logic [11:0]        w_d;
    logic [5:0]         w_dcap;
    logic [63:0]        w_ext;
    logic [EXT_W:0]     w_sum;
    logic [5:0]         w_pos;
    logic [5:0]         w_lsh;
    logic [SIG_W:0]     w_rnd;
    logic               w_emit;
    logic               w_normal;
    logic signed [11:0] w_ds;
    logic [5:0]         w_sh;
    logic [63:0]        w_wide;
    logic [63:0]        w_kept;
    logic               w_g;
    logic               w_st;
    logic               w_inc;
    logic [11:0]        w_biased;
    logic [31:0]        w_mag;
    logic [31:0]        w_f32;

    assign w_cur        = r_idx ? r_item.second : r_item.first;
    assign w_last_elem  = r_idx || !r_item.second_present;
    assign w_after      = !w_last_elem ? S_NORM : (r_item.row_end ? S_EMIT : S_IDLE);
    assign w_norm_short = r_acc_nan | w_cur.nan | w_cur.inf | r_acc_inf | w_cur.zero
                        | r_acc_zero;
    assign w_emit       = (r_state == S_EMIT) && (!r_out_valid || i_pop);

    always_comb begin
        w_k = '0;
        for (int i = 0; i < 32; i++) begin
            if (w_cur.prod[i]) w_k = 5'(i);
        end
        w_pos = '0;
        for (int i = 0; i <= EXT_W; i++) begin
            if (r_sum[i]) w_pos = 6'(i);
        end
    end

    always_comb begin
        w_a_ge = (r_acc_exp > r_b_exp) || ((r_acc_exp == r_b_exp) && (r_acc_sig >= r_b_sig));
        w_d    = w_a_ge ? 12'(r_acc_exp - r_b_exp) : 12'(r_b_exp - r_acc_exp);
        w_dcap = (w_d > 12'd63) ? 6'd63 : w_d[5:0];
        w_ext  = w_a_ge ? {8'b0, r_b_sig, 3'b0} : {8'b0, r_acc_sig, 3'b0};
        w_sum  = r_sub ? ({1'b0, r_big} - {1'b0, r_small}) : ({1'b0, r_big} + {1'b0, r_small});
        w_lsh  = 6'd55 - w_pos;
        w_rnd  = {1'b0, r_norm[EXT_W-1:3]}
               + {{SIG_W{1'b0}}, r_norm[2] & (r_norm[1] | r_norm[0] | r_norm[3])};
    end

    always_comb begin
        w_normal = (r_acc_exp >= -12'sd126);
        w_ds     = -12'sd126 - r_acc_exp;
        w_sh     = w_normal ? 6'd29 : ((w_ds > 12'sd34) ? 6'd63 : 6'd29 + w_ds[5:0]);
        w_wide   = {11'b0, r_acc_sig};
        w_kept   = w_wide >> w_sh;
        w_g      = w_wide[w_sh - 6'd1];
        w_st     = |(w_wide & ((64'd1 << (w_sh - 6'd1)) - 64'd1));
        w_inc    = w_g & (w_st | w_kept[0]);
        w_biased = 12'(r_acc_exp + 12'sd127);
        w_mag    = w_normal ? ({1'b0, w_biased[7:0], 23'b0} + {9'b0, w_kept[22:0]}
                               + {31'b0, w_inc})
                            : ({9'b0, w_kept[22:0]} + {31'b0, w_inc});
        if (r_acc_nan) begin
            w_f32 = F32_QNAN;
        end else if (r_acc_inf) begin
            w_f32 = {r_acc_sign, F32_INF[30:0]};
        end else if (r_acc_zero) begin
            w_f32 = {r_acc_sign, 31'b0};
        end else if ((r_acc_exp > 12'sd127) || (w_mag >= F32_INF)) begin
            w_f32 = {r_acc_sign, F32_INF[30:0]};
        end else begin
            w_f32 = {r_acc_sign, w_mag[30:0]};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_q_empty) n_state = S_NORM;
            S_NORM:  n_state = w_norm_short ? w_after : S_ALIGN;
            S_ALIGN: n_state = S_ADD;
            S_ADD:   n_state = (w_sum == '0) ? w_after : S_LZC;
            S_LZC:   n_state = S_SHIFT;
            S_SHIFT: n_state = S_ROUND;
            S_ROUND: n_state = w_after;
            S_EMIT:  if (!r_out_valid || i_pop) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_state == S_IDLE) && !i_q_empty;
    end

    always_comb begin
        n_item      = r_item;
        n_idx       = r_idx;
        n_acc_sign  = r_acc_sign;
        n_acc_zero  = r_acc_zero;
        n_acc_inf   = r_acc_inf;
        n_acc_nan   = r_acc_nan;
        n_acc_exp   = r_acc_exp;
        n_acc_sig   = r_acc_sig;
        n_b_sign    = r_b_sign;
        n_b_exp     = r_b_exp;
        n_b_sig     = r_b_sig;
        n_big       = r_big;
        n_small     = r_small;
        n_exp       = r_exp;
        n_sign      = r_sign;
        n_sub       = r_sub;
        n_sum       = r_sum;
        n_lz        = r_lz;
        n_norm      = r_norm;
        n_out_valid = r_out_valid & !i_pop;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_item = i_item;
                    n_idx  = 1'b0;
                end
            end
            S_NORM: begin
                n_b_sign = w_cur.sign;
                n_b_exp  = $signed({{2{w_cur.expo[9]}}, w_cur.expo}) + $signed({7'b0, w_k});
                n_b_sig  = {21'b0, w_cur.prod} << (6'd52 - {1'b0, w_k});
                if (r_acc_nan || w_cur.nan) begin
                    n_acc_nan  = 1'b1;
                    n_acc_inf  = 1'b0;
                    n_acc_zero = 1'b0;
                end else if (w_cur.inf) begin
                    if (r_acc_inf && (r_acc_sign != w_cur.sign)) begin
                        n_acc_nan = 1'b1;
                        n_acc_inf = 1'b0;
                    end else begin
                        n_acc_inf  = 1'b1;
                        n_acc_sign = w_cur.sign;
                    end
                    n_acc_zero = 1'b0;
                end else if (r_acc_inf) begin
                    n_acc_inf = 1'b1;
                end else if (w_cur.zero) begin
                    if (r_acc_zero) n_acc_sign = r_acc_sign & w_cur.sign;
                end else if (r_acc_zero) begin
                    n_acc_zero = 1'b0;
                    n_acc_sign = w_cur.sign;
                    n_acc_exp  = $signed({{2{w_cur.expo[9]}}, w_cur.expo})
                               + $signed({7'b0, w_k});
                    n_acc_sig  = {21'b0, w_cur.prod} << (6'd52 - {1'b0, w_k});
                end
                if (w_norm_short && !w_last_elem) n_idx = 1'b1;
            end
            S_ALIGN: begin
                n_big   = w_a_ge ? {r_acc_sig, 3'b0} : {r_b_sig, 3'b0};
                n_small = EXT_W'(w_ext >> w_dcap)
                        | {{(EXT_W-1){1'b0}}, |(w_ext & ((64'd1 << w_dcap) - 64'd1))};
                n_exp   = w_a_ge ? r_acc_exp : r_b_exp;
                n_sign  = w_a_ge ? r_acc_sign : r_b_sign;
                n_sub   = r_acc_sign ^ r_b_sign;
            end
            S_ADD: begin
                n_sum = w_sum;
                if (w_sum == '0) begin
                    n_acc_zero = 1'b1;
                    n_acc_sign = 1'b0;
                    if (!w_last_elem) n_idx = 1'b1;
                end
            end
            S_LZC: begin
                n_lz = w_pos;
            end
            S_SHIFT: begin
                if (r_sum[EXT_W]) begin
                    n_norm = {r_sum[EXT_W:2], r_sum[1] | r_sum[0]};
                    n_exp  = r_exp + 12'sd1;
                end else begin
                    n_norm = r_sum[EXT_W-1:0] << (6'd55 - r_lz);
                    n_exp  = r_exp - $signed({6'b0, 6'd55 - r_lz});
                end
            end
            S_ROUND: begin
                n_acc_zero = 1'b0;
                n_acc_sign = r_sign;
                if (w_rnd[SIG_W]) begin
                    n_acc_sig = w_rnd[SIG_W:1];
                    n_acc_exp = r_exp + 12'sd1;
                end else begin
                    n_acc_sig = w_rnd[SIG_W-1:0];
                    n_acc_exp = r_exp;
                end
                if (!w_last_elem) n_idx = 1'b1;
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_f32;
                    n_acc_zero  = 1'b1;
                    n_acc_sign  = 1'b0;
                    n_acc_inf   = 1'b0;
                    n_acc_nan   = 1'b0;
                end
            end
            default: begin
                n_out_valid = r_out_valid & !i_pop;
            end
        endcase
        if (r_state == S_SHIFT) n_lz = w_lsh;
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_idx      <= n_idx;
        r_acc_exp  <= n_acc_exp;
        r_acc_sig  <= n_acc_sig;
        r_b_sign   <= n_b_sign;
        r_b_exp    <= n_b_exp;
        r_b_sig    <= n_b_sig;
        r_big      <= n_big;
        r_small    <= n_small;
        r_exp      <= n_exp;
        r_sign     <= n_sign;
        r_sub      <= n_sub;
        r_sum      <= n_sum;
        r_lz       <= n_lz;
        r_norm     <= n_norm;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc_sign  <= 1'b0;
            r_acc_zero  <= 1'b1;
            r_acc_inf   <= 1'b0;
            r_acc_nan   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc_sign  <= n_acc_sign;
            r_acc_zero  <= n_acc_zero;
            r_acc_inf   <= n_acc_inf;
            r_acc_nan   <= n_acc_nan;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_row_result = r_out_data;

`ifndef ASSERT_OFF
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE)) else $error("queue pop outside idle");
    a_acc_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_acc_zero && !r_acc_inf && !r_acc_nan) |-> r_acc_sig[SIG_W-1])
        else $error("accumulator not normalized");
    a_emit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_out_valid && r_acc_zero && !r_acc_inf && !r_acc_nan))
        else $error("row end did not load result and clear sum");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_acc_zero, r_acc_inf, r_acc_nan})) else $error("accumulator flags clash");
`endif

endmodule

[design/nvfp4_block_scaled_gemv.sv]
// NVFP4 block-scaled dot product of one matrix row.
// Input side is a queue: raise i_push with a word while o_full is low; each word
// holds two E2M1 weights, their E4M3 block scale and two binary32 activations.
// Result side is a queue: while o_empty is low, o_row_result holds the binary32
// sum of the row (round to nearest even) and i_pop takes it.
// Words are decoded and multiplied exactly on entry and wait in a two-word queue.
// The back end adds each product into a binary64 sum through one shared adder:
// an idle state loads a word; per element, a normalize state alone serves when
// the product or the sum is zero or special, else normalize, align, add, count,
// shift and round follow (add ends it on a zero sum). A row end rounds to binary32.
// The back end then holds in its result state while the result word is unread,
// and the input queue keeps taking words until it is full.
// Reset (synchronous, active low) empties both queues and sets the sum to +0.
`timescale 1ns / 1ps
module nvfp4_block_scaled_gemv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_weight_pair,
    input  logic [7:0]  i_block_scale,
    input  logic [31:0] i_activation_first,
    input  logic [31:0] i_activation_second,
    input  logic        i_second_present,
    input  logic        i_row_end,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_row_result
);
    import nvfp4_pkg::*;

    t_item w_front_item;
    t_item w_q_item;
    logic  w_q_wr;
    logic  w_q_empty;
    logic  w_q_pop;

    assign w_q_wr = i_push && !o_full;

    nvfp4_front u_front (
        .i_weight_pair       (i_weight_pair),
        .i_block_scale       (i_block_scale),
        .i_activation_first  (i_activation_first),
        .i_activation_second (i_activation_second),
        .i_second_present    (i_second_present),
        .i_row_end           (i_row_end),
        .o_item              (w_front_item)
    );

    nvfp4_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_data  (w_front_item),
        .o_full  (o_full),
        .i_rd    (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_item)
    );

    nvfp4_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_q_item),
        .i_q_empty    (w_q_empty),
        .o_q_pop      (w_q_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_row_result (o_row_result)
    );

endmodule
